// ----- design/spibb_pkg.sv -----
package spibb_pkg;

	localparam int BURST_WORDS   = 8;
	localparam int ADDRESS_BYTES = 6;

	localparam int ADDR_W      = 48;
	localparam int CNT_W       = 8;
	localparam int WR_W        = $clog2(BURST_WORDS + 1);
	localparam int RB_AW       = (BURST_WORDS > 1) ? $clog2(BURST_WORDS) : 1;
	localparam int BURST_BYTES = 4 * BURST_WORDS;

	localparam logic [CNT_W-1:0] CNT_MAX = 8'd255;

	localparam logic [1:0] ACT_START = 2'd0;
	localparam logic [1:0] ACT_BYTE  = 2'd1;
	localparam logic [1:0] ACT_END   = 2'd2;
	localparam logic [1:0] ACT_RET   = 2'd3;

	localparam logic [2:0] KIND_WRITE    = 3'd0;
	localparam logic [2:0] KIND_READ_REQ = 3'd1;
	localparam logic [2:0] KIND_STAT_REQ = 3'd2;
	localparam logic [2:0] KIND_MISO     = 3'd3;
	localparam logic [2:0] KIND_BAD_CMD  = 3'd4;
	localparam logic [2:0] KIND_UNDERRUN = 3'd5;

	localparam logic [1:0] SIZE_BYTE  = 2'd0;
	localparam logic [1:0] SIZE_HALF  = 2'd1;
	localparam logic [1:0] SIZE_WORD  = 2'd2;
	localparam logic [1:0] SIZE_BURST = 2'd3;

	localparam logic [7:0] CMD_WR_WORD   = 8'h01;
	localparam logic [7:0] CMD_WR_BYTE   = 8'h0b;
	localparam logic [7:0] CMD_WR_HALF   = 8'h09;
	localparam logic [7:0] CMD_WR_BURST  = 8'h03;
	localparam logic [7:0] CMD_LATCH     = 8'h00;
	localparam logic [7:0] CMD_LATCH_BST = 8'h02;
	localparam logic [7:0] CMD_RD_BYTE   = 8'h1a;
	localparam logic [7:0] CMD_RD_HALF   = 8'h18;
	localparam logic [7:0] CMD_RD_WORD   = 8'h16;
	localparam logic [7:0] CMD_STATUS    = 8'h04;

	typedef struct packed {
		logic [1:0]  action;
		logic [7:0]  mosi_byte;
		logic [31:0] return_word;
	} in_item_t;

	typedef struct packed {
		logic [2:0]        kind;
		logic [ADDR_W-1:0] bus_address;
		logic [1:0]        size_code;
		logic [31:0]       write_data;
		logic [7:0]        miso_byte;
		logic              last;
	} out_item_t;

	function automatic logic [CNT_W-1:0] write_len(input logic [7:0] cmd);
		case (cmd)
			CMD_WR_BYTE:  write_len = 8'd1;
			CMD_WR_HALF:  write_len = 8'd2;
			CMD_WR_WORD:  write_len = 8'd4;
			CMD_WR_BURST: write_len = CNT_W'(BURST_BYTES);
			default:      write_len = 8'd0;
		endcase
	endfunction

	function automatic logic [CNT_W-1:0] read_len(input logic [7:0] cmd, input logic burst);
		case (cmd)
			CMD_RD_BYTE: read_len = 8'd1;
			CMD_RD_HALF: read_len = 8'd2;
			CMD_RD_WORD: read_len = burst ? CNT_W'(BURST_BYTES) : 8'd4;
			default:     read_len = 8'd0;
		endcase
	endfunction

endpackage

// ----- design/spi_to_bus_bridge_slave_unit.sv -----
// Slave side of an SPI-to-bus bridge.
// Input channel (item_valid / item_stall / item): one word per SPI event:
// frame start, MOSI byte, frame end, or a read word returned by the bus.
// Output channel (result_valid / result_stall / result): bus write,
// bus read request, status read request, MISO byte, bad command or
// underrun, at most one per input word.
// A word is taken at an edge where valid is high and stall is low.
// A result reaches the output from its input word through the input
// register, then the result register.
// Throughput: one input word per cycle while the result side is not
// stalled; all decode work for a word sits between the two registers.
// When result_stall holds, the result register keeps its word, the input
// register fills, and item_stall rises once both are occupied.
// Reset clears frame state, the latched read address and the returned
// word count; the read word buffer needs no clearing, since an entry is
// only read after it has been returned.
module spi_to_bus_bridge_slave_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  spibb_pkg::in_item_t  item,
	output logic                 result_valid,
	input  logic                 result_stall,
	output spibb_pkg::out_item_t result
);
	import spibb_pkg::*;

	logic      valid_s1;
	in_item_t  item_s1;
	logic      adv;
	logic      fire;
	logic      core_valid;
	out_item_t core_res;
	logic      result_valid_q;
	out_item_t result_q;

	assign adv        = !result_valid_q || !result_stall;
	assign item_stall = valid_s1 && !adv;
	assign fire       = valid_s1 && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!item_stall && item_valid) begin
			item_s1 <= item;
		end
	end

	spibb_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.item      (item_s1),
		.res_valid (core_valid),
		.res       (core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (adv) begin
			result_valid_q <= fire && core_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result_q <= core_res;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// ----- design/spibb_core.sv -----
module spibb_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  spibb_pkg::in_item_t  item,
	output logic                 res_valid,
	output spibb_pkg::out_item_t res
);
	import spibb_pkg::*;

	logic                in_frame_q, in_frame_d;
	logic [7:0]          cmd_q, cmd_d;
	logic [CNT_W-1:0]    cnt_q, cnt_d;
	logic                bad_q, bad_d;
	logic [ADDR_W-1:0]   addr_q, addr_d;
	logic [31:0]         data_q, data_d;
	logic [ADDR_W-1:0]   rd_addr_q, rd_addr_d;
	logic                rd_burst_q, rd_burst_d;
	logic [WR_W-1:0]     wr_q, wr_d;
	logic [31:0]         rb_q [BURST_WORDS];

	logic [7:0]          b;
	logic [CNT_W-1:0]    p;
	logic [ADDR_W-1:0]   addr_nx;
	logic [31:0]         data_nx;
	logic [CNT_W-1:0]    wlen;
	logic [CNT_W-1:0]    rlen_b;
	logic                is_latch;
	logic [CNT_W-1:0]    d;
	logic [5:0]          k;

	// read byte path
	logic [CNT_W-1:0]    sb_r, sb_n;
	logic [5:0]          sb_w;
	logic                sb_none, sb_under, sb_last;
	logic [1:0]          sb_sel;
	logic [31:0]         sb_word;
	logic [7:0]          sb_byte;
	out_item_t           sb_res;

	assign b       = item.mosi_byte;
	assign p       = cnt_q;
	assign addr_nx = {addr_q[ADDR_W-9:0], b};
	assign data_nx = {data_q[23:0], b};
	assign wlen    = write_len(cmd_q);
	assign rlen_b  = read_len(b, rd_burst_q);
	assign is_latch = (cmd_q == CMD_LATCH) || (cmd_q == CMD_LATCH_BST);
	assign d       = CNT_W'(p - CNT_W'(ADDRESS_BYTES) - 8'd1);
	assign k       = d[7:2];

	always_comb begin
		if (cmd_q == CMD_STATUS) begin
			sb_r = CNT_W'(p - 8'd2);
			sb_n = 8'd4;
		end else begin
			sb_r = CNT_W'(p - 8'd1);
			sb_n = read_len(cmd_q, rd_burst_q);
		end
		sb_w     = sb_r[7:2];
		sb_none  = sb_r >= sb_n;
		sb_under = (8'(sb_w) >= 8'(wr_q)) || (8'(sb_w) >= 8'(BURST_WORDS));
		sb_last  = sb_r == CNT_W'(sb_n - 8'd1);
		if (sb_n >= 8'd4) begin
			sb_sel = 2'd3 - sb_r[1:0];
		end else if (sb_n == 8'd2) begin
			sb_sel = {1'b0, ~sb_r[0]};
		end else begin
			sb_sel = 2'd0;
		end
		sb_word = rb_q[sb_w[RB_AW-1:0]];
		case (sb_sel)
			2'd0:    sb_byte = sb_word[7:0];
			2'd1:    sb_byte = sb_word[15:8];
			2'd2:    sb_byte = sb_word[23:16];
			default: sb_byte = sb_word[31:24];
		endcase
		sb_res      = '0;
		sb_res.last = sb_last;
		if (sb_under) begin
			sb_res.kind = KIND_UNDERRUN;
		end else begin
			sb_res.kind      = KIND_MISO;
			sb_res.miso_byte = sb_byte;
		end
	end

	always_comb begin
		in_frame_d = in_frame_q;
		cmd_d      = cmd_q;
		cnt_d      = cnt_q;
		bad_d      = bad_q;
		addr_d     = addr_q;
		data_d     = data_q;
		rd_addr_d  = rd_addr_q;
		rd_burst_d = rd_burst_q;
		wr_d       = wr_q;
		res_valid  = 1'b0;
		res        = '0;
		if (fire) begin
			case (item.action)
				ACT_START: begin
					in_frame_d = 1'b1;
					cmd_d      = '0;
					cnt_d      = '0;
					bad_d      = 1'b0;
					addr_d     = '0;
					data_d     = '0;
				end
				ACT_END: begin
					in_frame_d = 1'b0;
				end
				ACT_RET: begin
					if (wr_q < WR_W'(BURST_WORDS)) begin
						wr_d = WR_W'(wr_q + 1'b1);
					end
				end
				default: begin
					if (in_frame_q) begin
						if (cnt_q < CNT_MAX) begin
							cnt_d = CNT_W'(cnt_q + 8'd1);
						end
						if (p == '0) begin
							cmd_d = b;
							if (rlen_b != '0) begin
								wr_d            = '0;
								res_valid       = 1'b1;
								res.kind        = KIND_READ_REQ;
								res.bus_address = rd_addr_q;
								if (b == CMD_RD_BYTE) begin
									res.size_code = SIZE_BYTE;
								end else if (b == CMD_RD_HALF) begin
									res.size_code = SIZE_HALF;
								end else begin
									res.size_code = rd_burst_q ? SIZE_BURST : SIZE_WORD;
								end
							end else if (write_len(b) == '0 && b != CMD_LATCH
									&& b != CMD_LATCH_BST && b != CMD_STATUS) begin
								bad_d     = 1'b1;
								res_valid = 1'b1;
								res.kind  = KIND_BAD_CMD;
							end
						end else if (!bad_q) begin
							if (wlen != '0 || is_latch) begin
								if (p <= CNT_W'(ADDRESS_BYTES)) begin
									addr_d = addr_nx;
									if (p == CNT_W'(ADDRESS_BYTES) && wlen == '0) begin
										rd_addr_d  = addr_nx;
										rd_burst_d = cmd_q == CMD_LATCH_BST;
									end
								end else if (wlen != '0 && d < wlen) begin
									data_d = data_nx;
									if (wlen < 8'd4) begin
										if (d == CNT_W'(wlen - 8'd1)) begin
											res_valid       = 1'b1;
											res.kind        = KIND_WRITE;
											res.bus_address = addr_q;
											res.last        = 1'b1;
											if (wlen == 8'd1) begin
												res.size_code  = SIZE_BYTE;
												res.write_data = {24'd0, data_nx[7:0]};
											end else begin
												res.size_code  = SIZE_HALF;
												res.write_data = {16'd0, data_nx[15:0]};
											end
										end
									end else if (d[1:0] == 2'd3) begin
										res_valid       = 1'b1;
										res.kind        = KIND_WRITE;
										res.bus_address = ADDR_W'(addr_q + ADDR_W'({k, 2'b00}));
										res.size_code   = (cmd_q == CMD_WR_BURST) ?
											SIZE_BURST : SIZE_WORD;
										res.write_data  = data_nx;
										res.last        = 8'(k) == CNT_W'(wlen[7:2] - 6'd1);
									end
								end
							end else if (cmd_q == CMD_STATUS && p == 8'd1) begin
								wr_d            = '0;
								res_valid       = 1'b1;
								res.kind        = KIND_STAT_REQ;
								res.bus_address = ADDR_W'(b);
								res.size_code   = SIZE_WORD;
							end else if (!sb_none) begin
								res_valid = 1'b1;
								res       = sb_res;
							end
						end
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			cmd_q      <= '0;
			cnt_q      <= '0;
			bad_q      <= 1'b0;
			addr_q     <= '0;
			data_q     <= '0;
			rd_addr_q  <= '0;
			rd_burst_q <= 1'b0;
			wr_q       <= '0;
		end else begin
			in_frame_q <= in_frame_d;
			cmd_q      <= cmd_d;
			cnt_q      <= cnt_d;
			bad_q      <= bad_d;
			addr_q     <= addr_d;
			data_q     <= data_d;
			rd_addr_q  <= rd_addr_d;
			rd_burst_q <= rd_burst_d;
			wr_q       <= wr_d;
		end
	end

	// returned bus words
	always_ff @(posedge clk) begin
		if (fire && item.action == ACT_RET && wr_q < WR_W'(BURST_WORDS)) begin
			rb_q[wr_q[RB_AW-1:0]] <= item.return_word;
		end
	end

endmodule
